>>> rtl/core/jrb_pkg.sv
package jrb_pkg;

  // default reorder window, in slots
  localparam int JRB_WINDOW_DEPTH = 32;

  // field widths
  localparam int CHAN_W   = 32;
  localparam int SERIAL_W = 32;
  localparam int HANDLE_W = 16;
  localparam int THR_W    = 6;

  // stream payload widths
  localparam int IN_DATA_W  = 80;  // channel, serial, handle
  localparam int OUT_DATA_W = 48;  // serial, handle
  localparam int STATUS_W   = 3;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_ID = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLUSH_THR  = 2'd1;

  localparam logic [CHAN_W-1:0] CHANNEL_ID_RST = '0;
  localparam logic [THR_W-1:0]  FLUSH_THR_RST  = 6'd8;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_RELEASED = 3'd0,
    STAT_BUFFERED = 3'd1,
    STAT_WRONG_CH = 3'd2,
    STAT_STALE    = 3'd3,
    STAT_FAR      = 3'd4
  } jrb_status_t;

endpackage

>>> rtl/core/jitter_reorder_buffer.sv
// Jitter reorder buffer: puts the packets of one conversation back in serial order.
// Input beat (in_*): packet channel id, serial and payload handle. Packets on a
// channel other than cfg register channel_id come back with status wrong-channel.
// Output beats (out_*): one report per packet (released, buffered, stale, out of
// window, wrong channel), then one released beat per cached packet that follows
// on without a gap; out_tlast marks the final beat caused by an input packet.
// Handles of cached packets live in a one-port-read synchronous memory indexed
// by window slot; slot valid bits sit in flip-flops.
// Timing: an input beat is taken while idle; its first result is loaded into the
// output register from the evaluate state once that register is free, and the
// next beat is taken as the last result of the packet is offered. Each released
// cached packet takes a memory read state, then an output load; a flush steps
// over one skipped serial at a time while the slot walk looks for the lowest
// cached serial.
// in_tready is high only while no packet is in work.
// Reset clears expected serial, slot valid bits and cached count at once; the
// handle memory needs no clearing. A stalled receiver holds the output register
// and the walk waits on it; nothing is dropped.
module jitter_reorder_buffer #(
  parameter int WINDOW_DEPTH = jrb_pkg::JRB_WINDOW_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [jrb_pkg::IN_DATA_W-1:0]  in_tdata,   // packet_channel, packet_serial, payload_handle
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [jrb_pkg::OUT_DATA_W-1:0] out_tdata,  // out_serial, out_handle
  output logic [jrb_pkg::STATUS_W-1:0]   out_tuser,  // status
  output logic                           out_tlast,
  // configuration writes
  input  logic                           cfg_we,
  input  logic [jrb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jrb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import jrb_pkg::*;

  localparam int IW   = $clog2(WINDOW_DEPTH);  // slot index width
  localparam int CW   = $clog2(WINDOW_DEPTH);  // count holds up to depth-1
  localparam int CMPW = THR_W + 1;
  localparam logic [IW-1:0] LAST_SLOT = IW'(WINDOW_DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_SCAN,
    S_READ,
    S_EMIT
  } state_t;

  state_t                  state_r;
  logic [CHAN_W-1:0]       channel_id_r;
  logic [THR_W-1:0]        flush_thr_r;
  logic [SERIAL_W-1:0]     expected_r;
  logic [CW-1:0]           cached_count_r;
  logic [IW-1:0]           head_r;
  logic [WINDOW_DEPTH-1:0] slot_valid_r;

  logic [CHAN_W-1:0]       in_chan_r;
  logic [SERIAL_W-1:0]     in_serial_r;
  logic [HANDLE_W-1:0]     in_handle_r;

  logic                    out_valid_r;
  jrb_status_t             out_status_r;
  logic [SERIAL_W-1:0]     out_serial_r;
  logic [HANDLE_W-1:0]     out_handle_r;
  logic                    out_last_r;

  logic [HANDLE_W-1:0]     handle_mem [WINDOW_DEPTH];
  logic [HANDLE_W-1:0]     rd_data_r;

  logic                    out_free;
  logic                    out_load;
  logic [IW-1:0]           head_inc;
  logic                    chan_match;
  logic                    resync;
  logic [SERIAL_W-1:0]     ser_gap;
  logic                    gap_far;
  logic [IW:0]             slot_sum;
  logic [IW-1:0]           slot_ins;
  logic                    ins_dup;
  logic                    buf_go;
  logic                    flush_go;

  assign out_free = !out_valid_r || out_tready;
  assign out_load = out_free && ((state_r == S_EVAL) || (state_r == S_EMIT));
  assign head_inc = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;

  // classify the held packet against the window
  assign chan_match = (in_chan_r == channel_id_r);
  assign resync     = (expected_r == '0);
  assign ser_gap    = in_serial_r - expected_r;
  assign gap_far    = (ser_gap >= SERIAL_W'(WINDOW_DEPTH));
  assign slot_sum   = (IW+1)'(head_r) + (IW+1)'(ser_gap[IW-1:0]);
  assign slot_ins   = (slot_sum >= (IW+1)'(WINDOW_DEPTH)) ?
                      IW'(slot_sum - (IW+1)'(WINDOW_DEPTH)) : slot_sum[IW-1:0];
  assign ins_dup    = slot_valid_r[slot_ins];
  assign buf_go     = (state_r == S_EVAL) && out_free && chan_match && !resync &&
                      (ser_gap != '0) && !ser_gap[SERIAL_W-1] && !gap_far && !ins_dup;
  assign flush_go   = (CMPW'(cached_count_r) + CMPW'(1)) >= CMPW'(flush_thr_r);

  // handle memory: written when a packet is cached, read at the head slot
  always_ff @(posedge clk) begin
    if (buf_go) begin
      handle_mem[slot_ins] <= in_handle_r;
    end
    rd_data_r <= handle_mem[head_r];
  end

  // control, window state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      channel_id_r   <= CHANNEL_ID_RST;
      flush_thr_r    <= FLUSH_THR_RST;
      expected_r     <= '0;
      cached_count_r <= '0;
      head_r         <= '0;
      slot_valid_r   <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_CHANNEL_ID: channel_id_r <= cfg_wdata[CHAN_W-1:0];
          CFG_FLUSH_THR:  flush_thr_r  <= cfg_wdata[THR_W-1:0];
          default: ;
        endcase
      end

      // beat taken and nothing new loaded behind it
      if (out_valid_r && out_tready && !out_load) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            in_chan_r   <= in_tdata[CHAN_W-1:0];
            in_serial_r <= in_tdata[CHAN_W+SERIAL_W-1:CHAN_W];
            in_handle_r <= in_tdata[CHAN_W+SERIAL_W+HANDLE_W-1:CHAN_W+SERIAL_W];
            state_r     <= S_EVAL;
          end
        end

        // first result of the packet
        S_EVAL: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_serial_r <= in_serial_r;
            out_handle_r <= in_handle_r;
            if (!chan_match) begin
              out_status_r <= STAT_WRONG_CH;
              out_last_r   <= 1'b1;
              state_r      <= S_IDLE;
            end else if (resync) begin
              // start over: cache emptied, packet released at once
              slot_valid_r   <= '0;
              cached_count_r <= '0;
              head_r         <= IW'(1);
              expected_r     <= in_serial_r + 1'b1;
              out_status_r   <= STAT_RELEASED;
              out_last_r     <= 1'b1;
              state_r        <= S_IDLE;
            end else if (ser_gap == '0) begin
              expected_r   <= expected_r + 1'b1;
              head_r       <= head_inc;
              out_status_r <= STAT_RELEASED;
              out_last_r   <= !slot_valid_r[head_inc];
              state_r      <= slot_valid_r[head_inc] ? S_READ : S_IDLE;
            end else if (ser_gap[SERIAL_W-1]) begin
              out_status_r <= STAT_STALE;
              out_last_r   <= 1'b1;
              state_r      <= S_IDLE;
            end else if (gap_far) begin
              out_status_r <= STAT_FAR;
              out_last_r   <= 1'b1;
              state_r      <= S_IDLE;
            end else if (ins_dup) begin
              out_status_r <= STAT_STALE;
              out_last_r   <= 1'b1;
              state_r      <= S_IDLE;
            end else begin
              slot_valid_r[slot_ins] <= 1'b1;
              cached_count_r         <= cached_count_r + 1'b1;
              out_status_r           <= STAT_BUFFERED;
              out_last_r             <= !flush_go;
              state_r                <= flush_go ? S_SCAN : S_IDLE;
            end
          end
        end

        // flush: skip missing serials up to the lowest cached one
        S_SCAN: begin
          if (slot_valid_r[head_r]) begin
            state_r <= S_EMIT;
          end else begin
            head_r     <= head_inc;
            expected_r <= expected_r + 1'b1;
          end
        end

        // wait for the head slot's handle from the synchronous memory read
        S_READ: begin
          state_r <= S_EMIT;
        end

        // release the head slot and step on
        S_EMIT: begin
          if (out_free) begin
            out_valid_r          <= 1'b1;
            out_status_r         <= STAT_RELEASED;
            out_serial_r         <= expected_r;
            out_handle_r         <= rd_data_r;
            out_last_r           <= !slot_valid_r[head_inc];
            slot_valid_r[head_r] <= 1'b0;
            if (cached_count_r != '0) begin
              cached_count_r <= cached_count_r - 1'b1;
            end
            expected_r <= expected_r + 1'b1;
            head_r     <= head_inc;
            state_r    <= slot_valid_r[head_inc] ? S_READ : S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_handle_r, out_serial_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  // cached count tracks the number of occupied slots
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(slot_valid_r) == int'(cached_count_r))
    else $error("cached count differs from occupied slots");

  // the slot of the expected serial is never occupied between packets
  a_head_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !slot_valid_r[head_r])
    else $error("head slot occupied while idle");

  // a release only ever reads an occupied slot
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> slot_valid_r[head_r])
    else $error("release from an empty slot");

  // a release walk always follows a result that was not flagged last
  a_read_after_more: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == S_READ) |-> (out_valid_r && !out_last_r))
    else $error("release walk after a last beat");

endmodule
